### rtl/adc_scan_calibrate_monitor_defines.svh
// assertion macros for the adc scan block
`ifndef ADC_SCAN_CALIBRATE_MONITOR_DEFINES_SVH
`define ADC_SCAN_CALIBRATE_MONITOR_DEFINES_SVH

// concurrent check on the rising edge of clk, off during reset
`define ASCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication form of the same check
`define ASCM_ASSERT_IMP(lbl, pre, post, msg) \
  `ASCM_ASSERT(lbl, (pre) |-> (post), msg)

`endif

### rtl/ascm_pkg.sv
// ----------------------------------------------------------------------------
// ascm_pkg
// types, constants and codes shared by the adc scan and calibrate block
// ----------------------------------------------------------------------------
package ascm_pkg;

  localparam int NUM_CHANNELS_DEF = 16;

  localparam int MUL_STEPS = 32;
  localparam int DIV_STEPS = 67;

  localparam logic [2:0] CFG_SETTLE   = 3'd0;
  localparam logic [2:0] CFG_OC_LIMIT = 3'd1;
  localparam logic [2:0] CFG_OC_DEB   = 3'd2;
  localparam logic [2:0] CFG_HOLD     = 3'd3;

  localparam logic [3:0]  SETTLE_RST   = 4'd6;
  localparam logic [15:0] OC_LIMIT_RST = 16'd5000;
  localparam logic [7:0]  OC_DEB_RST   = 8'd3;
  localparam logic [7:0]  HOLD_RST     = 8'd20;

  localparam logic [3:0] CH_FIRST   = 4'd1;
  localparam logic [3:0] CH_R_REF   = 4'd10;
  localparam logic [3:0] CH_SKIP    = 4'd11;
  localparam logic [3:0] CH_SUP_HI  = 4'd13;
  localparam logic [3:0] CH_SUP_LO  = 4'd14;
  localparam logic [3:0] CH_R_MEAS  = 4'd15;

  localparam logic [31:0] SPAN_DIV     = 32'd10000000;
  localparam logic [31:0] CUR_MUL      = 32'd100000;
  localparam logic [31:0] CUR_DIV      = 32'd54169;
  localparam logic [31:0] SHUNT_DIV    = 32'd110;
  localparam logic [31:0] RES_MUL      = 32'd1000000;
  localparam logic [31:0] RES_DIV      = 32'd88727;
  localparam logic [31:0] RES_LEAK_MUL = 32'd10;
  localparam logic [31:0] ONE          = 32'd1;
  localparam logic [31:0] INVALID_OHMS = 32'd9999999;

  localparam logic [0:0] OP_CONV = 1'b0;
  localparam logic [0:0] OP_CAL  = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [23:0] raw_sample;
    logic        power_enable;
    logic [3:0]  cal_channel;
    logic [31:0] cal_zero;
    logic [31:0] cal_span;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]  mux_select;
    logic        sample_stored;
    logic [3:0]  stored_channel;
    logic [31:0] channel_volts;
    logic [31:0] supply_current;
    logic        overcurrent;
    logic [30:0] resistance_ohms;
  } out_beat_t;

  typedef struct packed {
    logic        start;
    logic [33:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } md_rsp_t;

  typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV, MD_SAT} md_state_t;

  typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_WAIT, ST_FIN} seq_state_t;

  typedef enum logic [2:0] {K_VOLT, K_C1, K_C2, K_R1, K_R2, K_R3} calc_t;

endpackage

### rtl/ascm_muldiv.sv
// ----------------------------------------------------------------------------
// ascm_muldiv
// bit-serial round(a * b / c), half away from zero, saturated to 32 bits
// ----------------------------------------------------------------------------
module ascm_muldiv (
  input  logic            clk,
  input  logic            rst,
  input  ascm_pkg::md_req_t req,
  output ascm_pkg::md_rsp_t rsp
);
  import ascm_pkg::*;

  md_state_t   state, state_next;
  logic [6:0]  count;
  logic        neg;
  logic [33:0] ma;
  logic [34:0] hi;
  logic [31:0] lo;
  logic [32:0] den;
  logic [66:0] num;
  logic [32:0] rem;
  logic [34:0] mul_sum;
  logic [33:0] div_t;
  logic        div_ge;
  logic [31:0] sat_val;
  logic        done;
  logic [31:0] result;

  assign rsp.done   = done;
  assign rsp.result = result;

  assign mul_sum = hi + (lo[0] ? {1'b0, ma} : 35'd0);
  assign div_t   = {rem, num[66]};
  assign div_ge  = div_t >= {1'b0, den};

  always_comb begin
    if (neg) begin
      if ((|num[66:32]) || (num[31] && (|num[30:0]))) sat_val = 32'h8000_0000;
      else sat_val = ~num[31:0] + 32'd1;
    end else begin
      if (|num[66:31]) sat_val = 32'h7fff_ffff;
      else sat_val = num[31:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      MD_IDLE: if (req.start) state_next = MD_MUL;
      MD_MUL:  if (count == 7'(MUL_STEPS - 1)) state_next = MD_DIV;
      MD_DIV:  if (count == 7'(DIV_STEPS - 1)) state_next = MD_SAT;
      MD_SAT:  state_next = MD_IDLE;
      default: state_next = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == MD_SAT);
      if (state != state_next) count <= '0;
      else count <= count + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      MD_IDLE: begin
        neg <= req.a[33] ^ req.b[31];
        ma  <= req.a[33] ? (~req.a + 34'd1) : req.a;
        lo  <= req.b[31] ? (~req.b + 32'd1) : req.b;
        hi  <= '0;
        den <= {req.c, 1'b0};
      end
      MD_MUL: begin
        hi <= {1'b0, mul_sum[34:1]};
        lo <= {mul_sum[0], lo[31:1]};
        if (count == 7'(MUL_STEPS - 1)) begin
          num <= {mul_sum[33:0], lo[31:1], 1'b0} + {35'd0, den[32:1]};
          rem <= '0;
        end
      end
      MD_DIV: begin
        if (div_ge) begin
          rem <= 33'(div_t - {1'b0, den});
          num <= {num[65:0], 1'b1};
        end else begin
          rem <= div_t[32:0];
          num <= {num[65:0], 1'b0};
        end
      end
      MD_SAT:  result <= sat_val;
      default: ;
    endcase
  end

endmodule

### rtl/adc_scan_calibrate_monitor.sv
// ----------------------------------------------------------------------------
// adc_scan_calibrate_monitor
// a settling conversion goes straight to its result beat; a stored one first runs
// 1, 3 or 4 multiply-divides in turn through the shared bit-serial unit, each of
// 32 multiply and 67 divide steps; one beat at a time, the input stalls until the
// result beat is loaded into the output register
// reset: synchronous, control registers and tables back to their reset values at once
// ----------------------------------------------------------------------------
module adc_scan_calibrate_monitor #(
  parameter int NUM_CHANNELS = ascm_pkg::NUM_CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  ascm_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ascm_pkg::out_beat_t out_data
);
  import ascm_pkg::*;

  `include "adc_scan_calibrate_monitor_defines.svh"

  localparam int CW = $clog2(NUM_CHANNELS);

  logic [3:0]  settle_conversions;
  logic [15:0] overcurrent_limit;
  logic [7:0]  overcurrent_debounce;
  logic [7:0]  power_hold_scans;

  logic [3:0]  current_channel;
  logic [3:0]  settle_left;
  logic        last_power_enable;
  logic [7:0]  power_hold_left;
  logic [7:0]  debounce_left;
  logic        overcurrent_flag;
  logic [31:0] current_reg;
  logic [31:0] resistance_reg;
  logic [31:0] v10, v13, v14, v15;
  logic [31:0] zero_table [NUM_CHANNELS];
  logic [31:0] span_table [NUM_CHANNELS];

  seq_state_t  state, state_next;
  calc_t       step;
  logic        stored;
  logic [19:0] counts;
  logic        pe;
  logic [31:0] volts;
  logic [31:0] m1;
  logic [31:0] i_reg;

  md_req_t     md_req;
  md_rsp_t     md_rsp;

  logic        in_go;
  logic [23:0] raw;
  logic [23:0] raw_adj;
  logic [32:0] diff;
  logic [31:0] diff_sat;
  logic [3:0]  nxt;
  logic [7:0]  hold_tmp;
  logic [7:0]  deb_dec;

  ascm_muldiv u_md (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  assign in_stall = (state != ST_IDLE);
  assign in_go    = in_valid && !in_stall;
  assign raw      = in_data.raw_sample;
  assign raw_adj  = raw + (raw[23] ? 24'd15 : 24'd0);

  assign diff = {m1[31], m1} - {md_rsp.result[31], md_rsp.result};
  always_comb begin
    if (diff[32] != diff[31]) diff_sat = diff[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    else diff_sat = diff[31:0];
  end

  assign deb_dec = debounce_left - 8'd1;

  always_comb begin
    md_req.start = (state == ST_LOAD);
    md_req.a = '0;
    md_req.b = '0;
    md_req.c = ONE;
    case (step)
      K_VOLT: begin
        md_req.a = {{14{counts[19]}}, counts}
                 - {{2{zero_table[current_channel[CW-1:0]][31]}},
                    zero_table[current_channel[CW-1:0]]};
        md_req.b = span_table[current_channel[CW-1:0]];
        md_req.c = SPAN_DIV;
      end
      K_C1: begin
        md_req.a = {v13[31], v13[31], v13} - {v14[31], v14[31], v14};
        md_req.b = CUR_MUL;
        md_req.c = CUR_DIV;
      end
      K_C2: begin
        md_req.a = {v14[31], v14[31], v14};
        md_req.b = ONE;
        md_req.c = SHUNT_DIV;
      end
      K_R1: begin
        md_req.a = {v15[31], v15[31], v15} - {v10[31], v10[31], v10};
        md_req.b = RES_MUL;
        md_req.c = RES_DIV;
      end
      K_R2: begin
        md_req.a = {v10[31], v10[31], v10};
        md_req.b = RES_LEAK_MUL;
        md_req.c = SHUNT_DIV;
      end
      K_R3: begin
        md_req.a = {v10[31], v10[31], v10};
        md_req.b = RES_MUL;
        md_req.c = i_reg;
      end
      default: ;
    endcase
  end

  always_comb begin
    nxt = current_channel + 4'd1;
    if (nxt == CH_SKIP) nxt = CH_SUP_HI;
    hold_tmp = (pe && !last_power_enable) ? power_hold_scans : power_hold_left;
    if (hold_tmp != 8'd0) begin
      if (nxt < CH_SUP_HI || nxt > CH_SUP_LO) nxt = CH_SUP_HI;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_go && in_data.opcode == OP_CONV) begin
          if (settle_left <= 4'd1) state_next = ST_LOAD;
          else state_next = ST_FIN;
        end
      end
      ST_LOAD: state_next = ST_WAIT;
      ST_WAIT: begin
        if (md_rsp.done) begin
          case (step)
            K_VOLT: begin
              if (current_channel == CH_SUP_LO || current_channel == CH_R_MEAS)
                state_next = ST_LOAD;
              else state_next = ST_FIN;
            end
            K_C1:    state_next = ST_LOAD;
            K_C2:    state_next = ST_FIN;
            K_R1:    state_next = ST_LOAD;
            K_R2: begin
              if (diff_sat[31] || diff_sat == 32'd0 || v10[31] || v10 == 32'd0)
                state_next = ST_FIN;
              else state_next = ST_LOAD;
            end
            K_R3:    state_next = ST_FIN;
            default: state_next = ST_FIN;
          endcase
        end
      end
      ST_FIN:  if (!(out_valid && out_stall)) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= ST_IDLE;
      settle_conversions   <= SETTLE_RST;
      overcurrent_limit    <= OC_LIMIT_RST;
      overcurrent_debounce <= OC_DEB_RST;
      power_hold_scans     <= HOLD_RST;
      current_channel      <= CH_FIRST;
      settle_left          <= SETTLE_RST;
      last_power_enable    <= 1'b0;
      power_hold_left      <= '0;
      debounce_left        <= OC_DEB_RST;
      overcurrent_flag     <= 1'b0;
      current_reg          <= '0;
      resistance_reg       <= '0;
      v10                  <= '0;
      v13                  <= '0;
      v14                  <= '0;
      v15                  <= '0;
      out_valid            <= 1'b0;
      step                 <= K_VOLT;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        zero_table[k] <= '0;
        span_table[k] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == ST_FIN && !(out_valid && out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;

      if (cfg_write) begin
        case (cfg_index)
          CFG_SETTLE:   settle_conversions   <= cfg_data[3:0];
          CFG_OC_LIMIT: overcurrent_limit    <= cfg_data;
          CFG_OC_DEB:   overcurrent_debounce <= cfg_data[7:0];
          CFG_HOLD:     power_hold_scans     <= cfg_data[7:0];
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (in_go) begin
            if (in_data.opcode == OP_CAL) begin
              zero_table[in_data.cal_channel[CW-1:0]] <= in_data.cal_zero;
              span_table[in_data.cal_channel[CW-1:0]] <= in_data.cal_span;
            end else begin
              counts <= raw_adj[23:4];
              pe     <= in_data.power_enable;
              step   <= K_VOLT;
              volts  <= '0;
              stored <= (settle_left <= 4'd1);
            end
          end
        end
        ST_WAIT: begin
          if (md_rsp.done) begin
            case (step)
              K_VOLT: begin
                volts <= md_rsp.result;
                if (current_channel == CH_R_REF)  v10 <= md_rsp.result;
                if (current_channel == CH_SUP_HI) v13 <= md_rsp.result;
                if (current_channel == CH_SUP_LO) v14 <= md_rsp.result;
                if (current_channel == CH_R_MEAS) v15 <= md_rsp.result;
                step <= (current_channel == CH_SUP_LO) ? K_C1 : K_R1;
              end
              K_C1: begin
                m1   <= md_rsp.result;
                step <= K_C2;
              end
              K_C2: begin
                current_reg <= diff_sat;
                if ($signed(diff_sat) > $signed({16'd0, overcurrent_limit})) begin
                  debounce_left <= deb_dec;
                  if (deb_dec == 8'd0) overcurrent_flag <= 1'b1;
                end else begin
                  debounce_left    <= overcurrent_debounce;
                  overcurrent_flag <= 1'b0;
                end
              end
              K_R1: begin
                m1   <= md_rsp.result;
                step <= K_R2;
              end
              K_R2: begin
                i_reg <= diff_sat;
                step  <= K_R3;
                if (diff_sat[31] || diff_sat == 32'd0 || v10[31] || v10 == 32'd0)
                  resistance_reg <= INVALID_OHMS;
              end
              K_R3: resistance_reg <= md_rsp.result;
              default: ;
            endcase
          end
        end
        ST_FIN: begin
          if (!(out_valid && out_stall)) begin
            if (stored) begin
              last_power_enable <= pe;
              power_hold_left   <= (hold_tmp != 8'd0) ? hold_tmp - 8'd1 : hold_tmp;
              current_channel   <= nxt;
              settle_left       <= settle_conversions;
            end else begin
              settle_left <= settle_left - 4'd1;
            end
            out_data.mux_select      <= stored ? nxt : current_channel;
            out_data.sample_stored   <= stored;
            out_data.stored_channel  <= current_channel;
            out_data.channel_volts   <= volts;
            out_data.supply_current  <= current_reg;
            out_data.overcurrent     <= overcurrent_flag;
            out_data.resistance_ohms <= resistance_reg[30:0];
          end
        end
        default: ;
      endcase
    end
  end

  `ASCM_ASSERT_IMP(a_idle_volts, out_valid && !out_data.sample_stored, out_data.channel_volts == 32'd0, "volts on a settling beat")
  `ASCM_ASSERT_IMP(a_no_skip_sel, out_valid, out_data.mux_select != CH_SKIP && out_data.mux_select != 4'd12, "skipped channel selected")
  `ASCM_ASSERT_IMP(a_md_only_wait, md_rsp.done, state == ST_WAIT, "divider result outside wait")

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adc scan, calibrate and monitor testbench
// drives conversion and calibration-load beats with random gaps, models the
// channel scan, calibration math, supply current, overcurrent debounce and
// resistance derivation, and compares every result beat in order
// ----------------------------------------------------------------------------
import ascm_pkg::*;

class scan_tracker;
  logic [3:0]  settle_cfg;
  logic [15:0] limit_cfg;
  logic [7:0]  deb_cfg;
  logic [7:0]  hold_cfg;
  logic [3:0]  chan;
  logic [3:0]  settle_left;
  logic        last_pe;
  logic [7:0]  hold_left;
  logic [7:0]  deb_left;
  logic        oc_flag;
  int          current_val;
  int          ohms_val;
  int          volts_t[16];
  int          zero_t[16];
  int          span_t[16];
  out_beat_t   readings_due[$];
  int          errors;

  function new();
    errors = 0;
    settle_cfg = SETTLE_RST;
    limit_cfg = OC_LIMIT_RST;
    deb_cfg = OC_DEB_RST;
    hold_cfg = HOLD_RST;
    chan = CH_FIRST;
    settle_left = SETTLE_RST;
    last_pe = 1'b0;
    hold_left = 8'd0;
    deb_left = OC_DEB_RST;
    oc_flag = 1'b0;
    current_val = 0;
    ohms_val = 0;
    foreach (volts_t[i]) begin
      volts_t[i] = 0;
      zero_t[i] = 0;
      span_t[i] = 0;
    end
  endfunction

  function void write_reg(logic [2:0] idx, logic [15:0] v);
    case (idx)
      CFG_SETTLE:   settle_cfg = v[3:0];
      CFG_OC_LIMIT: limit_cfg = v;
      CFG_OC_DEB:   deb_cfg = v[7:0];
      CFG_HOLD:     hold_cfg = v[7:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return readings_due.size();
  endfunction

  static function int sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  // rounded a*b/c, half away from zero, saturated
  static function int muldiv(longint a, longint b, longint c);
    longint p;
    bit neg;
    longint unsigned mag;
    longint unsigned cu;
    longint unsigned q;
    p = a * b;
    neg = p < 0;
    mag = neg ? longint'(-p) : p;
    cu = c;
    q = (2 * mag + cu) / (2 * cu);
    if (neg) begin
      if (q > 64'd2147483648) return 32'sh80000000;
      return int'(-longint'(q));
    end
    if (q > 64'd2147483647) return 32'sh7fffffff;
    return int'(q);
  endfunction

  function void accept_input(in_beat_t b);
    logic [3:0] ch;
    logic [3:0] nxt;
    int raw;
    int counts;
    int volts;
    int v10;
    int leak_i;
    out_beat_t r;
    if (b.opcode == OP_CAL) begin
      zero_t[b.cal_channel] = b.cal_zero;
      span_t[b.cal_channel] = b.cal_span;
      return;
    end
    ch = chan;
    volts = 0;
    r.sample_stored = 1'b0;
    if (settle_left <= 1) begin
      raw = int'($signed(b.raw_sample));
      counts = raw / 16;
      r.sample_stored = 1'b1;
      volts = muldiv(longint'(counts) - zero_t[ch], span_t[ch], SPAN_DIV);
      volts_t[ch] = volts;
      if (ch == CH_SUP_LO) begin
        current_val = sat32(longint'(muldiv(longint'(volts_t[13]) - volts_t[14],
                                            CUR_MUL, CUR_DIV))
                            - muldiv(volts_t[14], ONE, SHUNT_DIV));
        if (longint'(current_val) > longint'(limit_cfg)) begin
          deb_left = deb_left - 8'd1;
          if (deb_left == 8'd0) oc_flag = 1'b1;
        end else begin
          deb_left = deb_cfg;
          oc_flag = 1'b0;
        end
      end
      if (ch == CH_R_MEAS) begin
        v10 = volts_t[CH_R_REF];
        leak_i = sat32(longint'(muldiv(longint'(volts_t[15]) - v10, RES_MUL, RES_DIV))
                       - muldiv(v10, RES_LEAK_MUL, SHUNT_DIV));
        if (leak_i <= 0 || v10 <= 0) ohms_val = INVALID_OHMS;
        else ohms_val = muldiv(v10, RES_MUL, leak_i);
      end
      nxt = ch + 4'd1;
      if (nxt == CH_SKIP) nxt = CH_SUP_HI;
      if (b.power_enable && !last_pe) hold_left = hold_cfg;
      last_pe = b.power_enable;
      if (hold_left != 8'd0) begin
        if (nxt < CH_SUP_HI || nxt > CH_SUP_LO) nxt = CH_SUP_HI;
        hold_left = hold_left - 8'd1;
      end
      chan = nxt;
      settle_left = settle_cfg;
    end else begin
      settle_left = settle_left - 4'd1;
    end
    r.mux_select = chan;
    r.stored_channel = ch;
    r.channel_volts = volts;
    r.supply_current = current_val;
    r.overcurrent = oc_flag;
    r.resistance_ohms = ohms_val[30:0];
    readings_due.push_back(r);
  endfunction

  function void match_reading(out_beat_t a);
    out_beat_t e;
    if (readings_due.size() == 0) begin
      $error("unexpected result beat %h", a);
      errors++;
      return;
    end
    e = readings_due.pop_front();
    if (a.mux_select !== e.mux_select) begin
      $error("mux_select exp %0d got %0d", e.mux_select, a.mux_select);
      errors++;
    end
    if (a.sample_stored !== e.sample_stored) begin
      $error("sample_stored exp %0d got %0d", e.sample_stored, a.sample_stored);
      errors++;
    end
    if (a.stored_channel !== e.stored_channel) begin
      $error("stored_channel exp %0d got %0d", e.stored_channel, a.stored_channel);
      errors++;
    end
    if (a.channel_volts !== e.channel_volts) begin
      $error("channel_volts exp %0d got %0d", $signed(e.channel_volts),
             $signed(a.channel_volts));
      errors++;
    end
    if (a.supply_current !== e.supply_current) begin
      $error("supply_current exp %0d got %0d", $signed(e.supply_current),
             $signed(a.supply_current));
      errors++;
    end
    if (a.overcurrent !== e.overcurrent) begin
      $error("overcurrent exp %0d got %0d", e.overcurrent, a.overcurrent);
      errors++;
    end
    if (a.resistance_ohms !== e.resistance_ohms) begin
      $error("resistance_ohms exp %0d got %0d", e.resistance_ohms, a.resistance_ohms);
      errors++;
    end
  endfunction
endclass

module testbench;
  localparam int DRAIN_CYCLES = 800;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [15:0] cfg_data = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_beat_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_data;

  scan_tracker tracker = new();
  bit          burst = 1'b0;
  bit          pe_level = 1'b0;
  int          results_seen = 0;

  adc_scan_calibrate_monitor dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #80000000;
    $display("adc_scan_calibrate_monitor verification failed");
    $finish;
  end

  // result side: check accepted beats, random stall per beat, one long hold
  initial begin
    int stall_left;
    int long_hold;
    bit long_done;
    stall_left = 0;
    long_hold = 0;
    long_done = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        tracker.match_reading(out_data);
        results_seen++;
        stall_left = burst ? 0 : $urandom_range(0, 16);
        if (results_seen == 120 && !long_done) begin
          long_hold = 1500;
          long_done = 1;
        end
      end
      if (long_hold > 0) begin
        long_hold--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_beat(in_beat_t b);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    tracker.accept_input(b);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [15:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    tracker.write_reg(idx, v);
    @(posedge clk);
  endtask

  function automatic in_beat_t make_cal(logic [3:0] ch, logic [31:0] z, logic [31:0] s);
    in_beat_t b;
    b.opcode = OP_CAL;
    b.raw_sample = 24'($urandom());
    b.power_enable = pe_level;
    b.cal_channel = ch;
    b.cal_zero = z;
    b.cal_span = s;
    return b;
  endfunction

  function automatic in_beat_t make_conv(logic [23:0] raw);
    in_beat_t b;
    b.opcode = OP_CONV;
    b.raw_sample = raw;
    b.power_enable = pe_level;
    b.cal_channel = 4'($urandom());
    b.cal_zero = $urandom();
    b.cal_span = $urandom();
    return b;
  endfunction

  function automatic in_beat_t random_beat();
    logic [31:0] z;
    logic [31:0] s;
    logic [23:0] raw;
    if ($urandom_range(0, 39) == 0) pe_level = ~pe_level;
    if ($urandom_range(0, 6) == 0) begin
      z = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 4000) - 2000;
      s = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 40000000);
      if ($urandom_range(0, 3) == 0) s = -s;
      return make_cal(4'($urandom_range(0, 15)), z, s);
    end
    raw = ($urandom_range(0, 3) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 2000000));
    return make_conv(raw);
  endfunction

  initial begin
    int ph;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: calibration extremes, sample extremes, truncation toward zero
    send_beat(make_cal(4'd0, 32'h80000000, 32'h7fffffff));
    send_beat(make_cal(4'd15, 32'h7fffffff, 32'h80000000));
    send_beat(make_cal(4'd1, 32'd0, 32'd10000000));
    send_beat(make_cal(4'd2, 32'hffffffff, 32'hff676980));
    send_beat(make_cal(4'd10, 32'd0, 32'd20000000));
    send_beat(make_cal(4'd13, 32'd0, 32'd30000000));
    send_beat(make_cal(4'd14, 32'd100, 32'd5000000));
    send_beat(make_conv(24'h7fffff));
    send_beat(make_conv(24'h800000));
    send_beat(make_conv(24'hfffff1));
    send_beat(make_conv(24'h00000f));
    send_beat(make_conv(24'hffffff));
    send_beat(make_conv(24'h000000));
    send_beat(make_conv(24'h800000));
    send_beat(make_conv(24'h7fffff));
    send_beat(make_conv(24'hfffff0));
    send_beat(make_conv(24'h000010));
    send_beat(make_conv(24'h123456));
    pe_level = 1'b1;
    send_beat(make_conv(24'h7fffff));
    send_beat(make_conv(24'h400000));

    for (ph = 0; ph < 6; ph++) begin
      wait_drained();
      case (ph)
        0: ;
        1: begin
          write_cfg(CFG_SETTLE, 16'd1);
          write_cfg(CFG_OC_LIMIT, 16'd0);
          write_cfg(CFG_OC_DEB, 16'd1);
          write_cfg(CFG_HOLD, 16'd0);
        end
        2: begin
          write_cfg(CFG_SETTLE, 16'd15);
          write_cfg(CFG_OC_LIMIT, 16'hffff);
          write_cfg(CFG_OC_DEB, 16'd255);
          write_cfg(CFG_HOLD, 16'd255);
        end
        3: begin
          write_cfg(CFG_SETTLE, 16'd0);
          write_cfg(CFG_OC_LIMIT, 16'($urandom_range(0, 3000)));
          write_cfg(CFG_OC_DEB, 16'd0);
          write_cfg(CFG_HOLD, 16'd2);
          write_cfg(3'd5, 16'($urandom()));
        end
        default: begin
          write_cfg(CFG_SETTLE, 16'($urandom_range(1, 4)));
          write_cfg(CFG_OC_LIMIT, 16'($urandom_range(0, 2000)));
          write_cfg(CFG_OC_DEB, 16'($urandom_range(1, 5)));
          write_cfg(CFG_HOLD, 16'($urandom_range(0, 30)));
          write_cfg(3'd7, 16'($urandom()));
        end
      endcase
      for (int n = 0; n < 315; n++) begin
        if (n % 50 == 0) burst = ($urandom_range(0, 3) == 0);
        if (ph == 1 && n == 150) begin
          in_valid <= 1'b0;
          while (tracker.pending() != 0) @(posedge clk);
        end
        send_beat(random_beat());
      end
    end

    burst = 1'b0;
    wait_drained();
    if (tracker.pending() != 0) begin
      $error("%0d result beats never arrived", tracker.pending());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("adc_scan_calibrate_monitor verification clean");
    end else begin
      $display("adc_scan_calibrate_monitor verification failed");
    end
    $finish;
  end
endmodule

### adc_scan_calibrate_monitor.f
+incdir+rtl
rtl/ascm_pkg.sv
rtl/ascm_muldiv.sv
rtl/adc_scan_calibrate_monitor.sv
tb/sv/testbench.sv
